// File: rtl/qslerp_pkg.sv
package qslerp_pkg;

  localparam int QW = 34;
  localparam logic signed [QW-1:0] QONE = 34'sd1073741824;
  localparam logic signed [QW-1:0] EPS_Q30 = 34'sd107;
  localparam logic signed [QW-1:0] INV_GAIN = 34'sd652032874;
  localparam int STEPS = 28;

  typedef logic signed [QW-1:0] q30_t;

  function automatic q30_t atan_step(input int i);
    q30_t r;
    r = '0;
    case (i)
      0: r = 34'sh3243F6A8;
      1: r = 34'sh1DAC6705;
      2: r = 34'sh0FADBAFC;
      3: r = 34'sh07F56EA6;
      4: r = 34'sh03FEAB76;
      5: r = 34'sh01FFD55B;
      6: r = 34'sh00FFFAAA;
      7: r = 34'sh007FFF55;
      8: r = 34'sh003FFFEA;
      9: r = 34'sh001FFFFD;
      default: r = (q30_t'(1) <<< (30 - i)) - q30_t'(1);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/qslerp_if.sv
interface qslerp_if #(
  parameter int W = 16
) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/qslerp_cordic.sv
module qslerp_cordic #(
  parameter bit VECTORING = 1'b0
) (
  input  logic clk,
  input  logic en,
  input  qslerp_pkg::q30_t x_in,
  input  qslerp_pkg::q30_t y_in,
  input  qslerp_pkg::q30_t z_in,
  output qslerp_pkg::q30_t y_out,
  output qslerp_pkg::q30_t z_out
);
  import qslerp_pkg::*;

  q30_t x [STEPS+1];
  q30_t y [STEPS+1];
  q30_t z [STEPS+1];

  assign x[0] = x_in;
  assign y[0] = y_in;
  assign z[0] = z_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic up;
    assign up = VECTORING ? (y[i] >= 0) : (z[i] >= 0);
    always_ff @(posedge clk) begin
      if (en) begin
        if (VECTORING ? up : !up) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
        end
        if (up) z[i+1] <= VECTORING ? z[i] + atan_step(i) : z[i] - atan_step(i);
        else z[i+1] <= VECTORING ? z[i] - atan_step(i) : z[i] + atan_step(i);
      end
    end
  end

  assign y_out = y[STEPS];
  assign z_out = z[STEPS];
endmodule

// File: rtl/qslerp_isqrt.sv
module qslerp_isqrt (
  input  logic clk,
  input  logic en,
  input  logic [60:0] n_in,
  output logic [30:0] root
);
  localparam int N = 31;
  logic [60:0] n   [N+1];
  logic [61:0] res [N+1];

  assign n[0] = n_in;
  assign res[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [61:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, n[k]} >= trial) begin
          n[k+1] <= n[k] - trial[60:0];
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          n[k+1] <= n[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign root = res[N][30:0];
endmodule

// File: rtl/qslerp_div.sv
module qslerp_div (
  input  logic clk,
  input  logic en,
  input  logic [30:0] num,
  input  logic [30:0] den,
  output logic [30:0] quo
);
  localparam int N = 31;
  logic [30:0] rem [N+1];
  logic [30:0] q   [N+1];
  logic [30:0] dv  [N+1];

  // numerator above the divisor saturates the quotient at 2^30
  assign rem[0] = (num > den) ? den : num;
  assign q[0] = '0;
  assign dv[0] = den;

  for (genvar k = 0; k < N; k++) begin : g_bit
    logic [31:0] r2;
    assign r2 = (k == 0) ? {1'b0, rem[k]} : {rem[k], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= dv[k];
        if (r2 >= {1'b0, dv[k]}) begin
          rem[k+1] <= 31'(r2 - {1'b0, dv[k]});
          q[k+1] <= {q[k][29:0], 1'b1};
        end else begin
          rem[k+1] <= r2[30:0];
          q[k+1] <= {q[k][29:0], 1'b0};
        end
      end
    end
  end

  assign quo = q[N];
endmodule

// File: rtl/quaternion_slerp.sv
// Throughput: one request per cycle unless a held result stalls the output; the
// whole pipeline advances together, set by the shift stages of the square root,
// CORDIC units and divider.
// A stall freezes every stage; the output register holds its result.
// Reset (rst, synchronous): clears all valid bits; data registers keep values.
module quaternion_slerp #(
  parameter int COMP_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  qslerp_if.sink   req,
  qslerp_if.source rsp
);
  import qslerp_pkg::*;

  localparam int CB = COMP_BITS;
  localparam int FB = FRAC_BITS;
  localparam int SH = 2 * (CB - 1) - 30;
  localparam int LAT_SQ = 31;
  localparam int LAT_AC = STEPS;
  localparam int LAT_S = STEPS;
  localparam int LAT_DV = 31;
  localparam int DEPTH = 3 + LAT_SQ + LAT_AC + 2 + LAT_S + 1 + LAT_DV + 2;

  typedef logic signed [CB:0] cw_t;

  typedef struct packed {
    logic signed [3:0][CB-1:0] a;
    logic signed [3:0][CB:0]   b;
    logic [FB:0] fr;
    logic sel_a;
    logic sel_b;
    logic lin;
  } carry_t;

  logic en;
  logic [DEPTH-1:0] vld;
  logic out_valid;
  logic [4*CB-1:0] out_data;

  assign en = !out_valid || rsp.ready;
  assign req.ready = en;

  // input unpack, stage 0: products
  logic signed [3:0][CB-1:0] ia, ib;
  logic [FB:0] ifr;
  assign ia = req.data[8*CB-1:4*CB];
  assign ib = req.data[4*CB-1:0];
  assign ifr = req.data[8*CB+FB:8*CB];

  carry_t c0, c1, c2, c2_next;
  logic signed [2*CB-1:0] prod [4];
  logic signed [63:0] p30 [4];
  logic signed [63:0] inner1;
  q30_t dot2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) prod[j] <= $signed(ia[j]) * $signed(ib[j]);
      c0.a <= ia;
      for (int j = 0; j < 4; j++) c0.b[j] <= cw_t'($signed(ib[j]));
      c0.fr <= ifr;
      c0.sel_a <= (ifr == '0);
      c0.sel_b <= ifr[FB];
      c0.lin <= 1'b0;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (SH >= 0) p30[j] = 64'(prod[j]) >>> SH;
      else p30[j] = 64'(prod[j]) <<< (-SH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inner1 <= p30[0] + p30[1] + p30[2] + p30[3];
      c1 <= c0;
    end
  end

  // stage 2: fold to shorter arc
  always_comb begin
    c2_next = c1;
    if (inner1 < 0 && !c1.sel_a && !c1.sel_b) begin
      for (int j = 0; j < 4; j++) c2_next.b[j] = -c1.b[j];
    end
    c2_next.lin = (QONE - QW'(inner1 < 0 ? -inner1 : inner1)) <= EPS_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c2_next;
      if (inner1 < 0) begin
        dot2 <= QW'(-inner1);
      end else begin
        dot2 <= QW'(inner1);
      end
    end
  end

  // dot2 stays below 2^31 when non-linear
  logic [60:0] sq_in;
  logic [61:0] dsq;
  assign dsq = 62'(dot2[30:0]) * 62'(dot2[30:0]);
  assign sq_in = c2.lin ? 61'd0 : 61'((62'd1 << 60) - dsq);

  logic [30:0] root;
  qslerp_isqrt u_sqrt (.clk(clk), .en(en), .n_in(sq_in), .root(root));

  carry_t csq [LAT_SQ+1];
  q30_t dsq_d [LAT_SQ+1];
  assign csq[0] = c2;
  assign dsq_d[0] = dot2;
  for (genvar k = 0; k < LAT_SQ; k++) begin : g_dsq
    always_ff @(posedge clk) if (en) begin
      csq[k+1] <= csq[k];
      dsq_d[k+1] <= dsq_d[k];
    end
  end

  q30_t theta_raw, unused_y;
  qslerp_cordic #(.VECTORING(1'b1)) u_acos (
    .clk(clk), .en(en), .x_in(dsq_d[LAT_SQ]), .y_in(QW'(root)), .z_in('0),
    .y_out(unused_y), .z_out(theta_raw)
  );

  carry_t cac [LAT_AC+1];
  assign cac[0] = csq[LAT_SQ];
  for (genvar k = 0; k < LAT_AC; k++) begin : g_dac
    always_ff @(posedge clk) if (en) cac[k+1] <= cac[k];
  end

  // scaled angles
  logic [30:0] th_a;
  logic [FB+30:0] m1, m2;
  q30_t th, z1, z2;
  carry_t cm0, cm1;
  always_ff @(posedge clk) begin
    if (en) begin
      th_a <= theta_raw < 0 ? 31'd0 : theta_raw[30:0];
      cm0 <= cac[LAT_AC];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= (FB+31)'(((FB+1)'(1) << FB) - cm0.fr) * (FB+31)'(th_a);
      m2 <= (FB+31)'(cm0.fr) * (FB+31)'(th_a);
      th <= QW'(th_a);
      cm1 <= cm0;
    end
  end
  assign z1 = QW'(m1 >> FB);
  assign z2 = QW'(m2 >> FB);

  q30_t s0, s1, s2, zu0, zu1, zu2;
  qslerp_cordic #(.VECTORING(1'b0)) u_s0 (
    .clk(clk), .en(en), .x_in(INV_GAIN), .y_in('0), .z_in(th), .y_out(s0), .z_out(zu0));
  qslerp_cordic #(.VECTORING(1'b0)) u_s1 (
    .clk(clk), .en(en), .x_in(INV_GAIN), .y_in('0), .z_in(z1), .y_out(s1), .z_out(zu1));
  qslerp_cordic #(.VECTORING(1'b0)) u_s2 (
    .clk(clk), .en(en), .x_in(INV_GAIN), .y_in('0), .z_in(z2), .y_out(s2), .z_out(zu2));

  carry_t csn [LAT_S+1];
  assign csn[0] = cm1;
  for (genvar k = 0; k < LAT_S; k++) begin : g_dsn
    always_ff @(posedge clk) if (en) csn[k+1] <= csn[k];
  end

  // divider setup: signs and magnitudes
  carry_t cdv, cdv_next;
  logic [30:0] n1, n2, dd;
  logic ng1, ng2;
  always_comb begin
    cdv_next = csn[LAT_S];
    cdv_next.lin = csn[LAT_S].lin || (s0 <= EPS_Q30);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cdv <= cdv_next;
      dd <= (s0 <= EPS_Q30) ? 31'd1 : s0[30:0];
      ng1 <= s1 < 0;
      ng2 <= s2 < 0;
      n1 <= s1 < 0 ? 31'd0 : s1[30:0];
      n2 <= s2 < 0 ? 31'd0 : s2[30:0];
    end
  end

  logic [30:0] q1, q2;
  qslerp_div u_div1 (.clk(clk), .en(en), .num(n1), .den(dd), .quo(q1));
  qslerp_div u_div2 (.clk(clk), .en(en), .num(n2), .den(dd), .quo(q2));

  carry_t cdd [LAT_DV+1];
  logic ngd1 [LAT_DV+1];
  logic ngd2 [LAT_DV+1];
  assign cdd[0] = cdv;
  assign ngd1[0] = ng1;
  assign ngd2[0] = ng2;
  for (genvar k = 0; k < LAT_DV; k++) begin : g_ddv
    always_ff @(posedge clk) if (en) begin
      cdd[k+1] <= cdd[k];
      ngd1[k+1] <= ngd1[k];
      ngd2[k+1] <= ngd2[k];
    end
  end

  // weights
  carry_t cw;
  logic [30:0] wa, wb;
  carry_t cf;
  always_ff @(posedge clk) begin
    if (en) begin
      cw <= cdd[LAT_DV];
      if (cdd[LAT_DV].lin) begin
        wa <= 31'((((FB+1)'(1) << FB) - cdd[LAT_DV].fr)) << (30 - FB);
        wb <= 31'(cdd[LAT_DV].fr) << (30 - FB);
      end else begin
        wa <= ngd1[LAT_DV] ? 31'd0 : (q1 > 31'(QONE) ? 31'(QONE) : q1);
        wb <= ngd2[LAT_DV] ? 31'd0 : (q2 > 31'(QONE) ? 31'(QONE) : q2);
      end
    end
  end

  logic signed [CB+32:0] pa [4];
  logic signed [CB+32:0] pb [4];
  always_ff @(posedge clk) begin
    if (en) begin
      cf <= cw;
      for (int j = 0; j < 4; j++) begin
        pa[j] <= (CB+33)'($signed(cw.a[j])) * (CB+33)'($signed({1'b0, wa}));
        pb[j] <= (CB+33)'($signed(cw.b[j])) * (CB+33)'($signed({1'b0, wb}));
      end
    end
  end

  logic signed [CB+33:0] acc [4];
  logic signed [CB+33:0] rsh [4];
  logic [3:0][CB-1:0] res;
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc[j] = (CB+34)'(pa[j]) + (CB+34)'(pb[j]) + (CB+34)'(QONE >>> 1);
      rsh[j] = acc[j] >>> 30;
      if (cf.sel_a) res[j] = cf.a[j];
      else if (cf.sel_b) res[j] = cf.b[j][CB-1:0];
      else if (rsh[j] < -((CB+34)'(1) <<< (CB - 1))) res[j] = {1'b1, {(CB-1){1'b0}}};
      else if (rsh[j] > ((CB+34)'(1) <<< (CB - 1)) - 1) res[j] = {1'b0, {(CB-1){1'b1}}};
      else res[j] = rsh[j][CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], req.valid};
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= res;
  end

  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result changed under stall");
  a_pipe_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(vld[DEPTH-1]))
    else $error("result without a request");
endmodule
